// File: rtl/core/m4acc_pkg.sv
// Shared constants, opcodes and request/result types of the 4x4 matrix accumulate unit.
package m4acc_pkg;

    localparam int DIM        = 4;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int NELEM      = DIM * DIM;
    localparam int ELEM_W     = $clog2(NELEM);
    localparam int DIM_W      = $clog2(DIM);
    localparam int READ_COUNT = (NELEM < 16) ? NELEM : 16;
    localparam int SUM_W      = DATA_W + DIM_W + 1;

    localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(64'sd1 <<< FRAC_BITS);

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_MUL   = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_CMP   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic KIND_ELEM = 1'b0;
    localparam logic KIND_CMP  = 1'b1;

    // One bit for each element that sits on the main diagonal.
    function automatic logic [NELEM-1:0] diag_mask();
        logic [NELEM-1:0] m;
        m = '0;
        for (int d = 0; d < DIM; d++)
        begin
            m[d * DIM + d] = 1'b1;
        end
        return m;
    endfunction

    localparam logic [NELEM-1:0] DIAG_MASK = diag_mask();

    typedef struct packed {
        logic [2:0]               op;
        logic [3:0]               elem_index;
        logic signed [DATA_W-1:0] elem_value;
    } cmd_t;

    typedef struct packed {
        logic                     kind;
        logic [3:0]               out_index;
        logic signed [DATA_W-1:0] out_value;
        logic                     equal;
        logic                     last;
    } rsp_t;

endpackage

// File: rtl/core/matrix4_accumulate_unit.sv
// Top level of the 4x4 fixed-point matrix accumulate unit.
// The unit keeps a DIM x DIM Q16.16 accumulator (identity after reset) in a
// one-port-write, one-port-read memory, and an operand matrix in a second one.
// A write or operand load request writes its element when it is taken. The load of the last
// element starts the operation: a multiply reads one accumulator and one
// operand element per cycle into a single multiplier, then drains the
// pipeline and writes the row back from scratch. An add holds cmd_ready low
// until every element has been added and written back, and a compare offers
// its result once all elements are compared and the result register is free. A read-out
// issues each element only when the previous one has left the pipeline and
// the result register is free, so it is paced by the accumulator read
// port and the result register. cmd_ready is low while an operation runs;
// a finished result waits in the result register without blocking requests.
module matrix4_accumulate_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  m4acc_pkg::cmd_t    cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output m4acc_pkg::rsp_t    rsp
);
    import m4acc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_RUN,
        S_MUL_DRAIN,
        S_MUL_WB,
        S_ADD_RUN,
        S_ADD_FIN,
        S_CMP_RUN,
        S_CMP_FIN,
        S_CMP_OUT,
        S_RD_RUN
    } state_t;

    typedef enum logic [1:0] {
        T_MUL,
        T_ADD,
        T_CMP,
        T_RD
    } tag_kind_t;

    typedef struct packed {
        logic              vld;
        tag_kind_t         kind;
        logic [ELEM_W-1:0] idx;
        logic [DIM_W-1:0]  col;
        logic              first;
        logic              last;
    } tag_t;

    function automatic logic [ELEM_W-1:0] elem_addr(input logic [DIM_W-1:0] r,
                                                    input logic [DIM_W-1:0] c);
        return ELEM_W'(int'(r) * DIM + int'(c));
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_wide(
        input logic signed [2*DATA_W-1:0] v);
        logic [DATA_W:0] top;
        top = v[2*DATA_W-1:DATA_W-1];
        if ((&top) || !(|top))
            return v[DATA_W-1:0];
        return v[2*DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-DATA_W:0] top;
        top = v[SUM_W-1:DATA_W-1];
        if ((&top) || !(|top))
            return v[DATA_W-1:0];
        return v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(input logic [DATA_W:0] v);
        if (v[DATA_W] == v[DATA_W-1])
            return v[DATA_W-1:0];
        return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    // Memories and their registered read data.
    logic signed [DATA_W-1:0] acc_mem [NELEM];
    logic signed [DATA_W-1:0] opnd_mem [NELEM];
    logic [NELEM-1:0]         acc_vld_reg;
    logic signed [DATA_W-1:0] acc_rdata_reg;
    logic                     acc_rvld_reg;
    logic                     acc_rdiag_reg;
    logic signed [DATA_W-1:0] opnd_rdata_reg;

    logic signed [DATA_W-1:0] scratch_reg [DIM];

    state_t                   state_reg;
    logic [DIM_W-1:0]         row_reg;
    logic [DIM_W-1:0]         col_reg;
    logic [DIM_W-1:0]         kk_reg;
    logic [ELEM_W-1:0]        seq_reg;
    rsp_t                     rsp_reg;
    logic                     rsp_valid_reg;

    tag_t                     p1_reg;
    tag_t                     p1_next;
    tag_t                     p2_reg;
    tag_t                     p2_next;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     eq_reg;

    logic                     accept;
    logic                     idx_ok;
    logic                     idx_final;
    logic [ELEM_W-1:0]        cmd_addr;
    logic                     slot_free;
    logic                     rd_issue;

    logic [ELEM_W-1:0]        acc_raddr;
    logic [ELEM_W-1:0]        opnd_raddr;
    logic                     acc_we;
    logic [ELEM_W-1:0]        acc_waddr;
    logic signed [DATA_W-1:0] acc_wdata;
    logic                     opnd_we;

    logic signed [DATA_W-1:0] acc_val;
    logic signed [DATA_W-1:0] add_val;
    logic signed [2*DATA_W-1:0] prod_shift;
    logic signed [DATA_W-1:0] term;
    logic signed [SUM_W-1:0]  sum_base;
    logic signed [SUM_W-1:0]  sum_next;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign idx_ok    = int'(cmd.elem_index) < NELEM;
    assign idx_final = int'(cmd.elem_index) == NELEM - 1;
    assign cmd_addr  = ELEM_W'(cmd.elem_index);
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rd_issue  = (state_reg == S_RD_RUN) && !p1_reg.vld && slot_free;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Read addresses and the tag that travels with each read.
    always_comb
    begin
        acc_raddr  = seq_reg;
        opnd_raddr = seq_reg;
        p1_next    = '0;
        p1_next.idx = seq_reg;
        p1_next.col = col_reg;
        case (state_reg)
            S_MUL_RUN:
            begin
                acc_raddr     = elem_addr(row_reg, kk_reg);
                opnd_raddr    = elem_addr(kk_reg, col_reg);
                p1_next.vld   = 1'b1;
                p1_next.kind  = T_MUL;
                p1_next.first = (kk_reg == '0);
                p1_next.last  = (int'(kk_reg) == DIM - 1);
            end
            S_ADD_RUN:
            begin
                p1_next.vld  = 1'b1;
                p1_next.kind = T_ADD;
            end
            S_CMP_RUN:
            begin
                p1_next.vld   = 1'b1;
                p1_next.kind  = T_CMP;
                p1_next.first = (seq_reg == '0);
            end
            S_RD_RUN:
            begin
                p1_next.vld  = rd_issue;
                p1_next.kind = T_RD;
                p1_next.last = (int'(seq_reg) == READ_COUNT - 1);
            end
            default:
            begin
                p1_next.vld = 1'b0;
            end
        endcase
    end

    // An entry never written since reset still holds its identity value.
    assign acc_val = acc_rvld_reg ? acc_rdata_reg : (acc_rdiag_reg ? FX_ONE : '0);
    assign add_val = sat_add({acc_val[DATA_W-1], acc_val} +
                             {opnd_rdata_reg[DATA_W-1], opnd_rdata_reg});

    // Only one writer of the accumulator is active in any cycle.
    always_comb
    begin
        acc_we    = 1'b0;
        acc_waddr = cmd_addr;
        acc_wdata = cmd.elem_value;
        if (accept && (cmd.op == OP_WRITE) && idx_ok)
        begin
            acc_we = 1'b1;
        end
        else if (p1_reg.vld && (p1_reg.kind == T_ADD))
        begin
            acc_we    = 1'b1;
            acc_waddr = p1_reg.idx;
            acc_wdata = add_val;
        end
        else if (state_reg == S_MUL_WB)
        begin
            acc_we    = 1'b1;
            acc_waddr = elem_addr(row_reg, col_reg);
            acc_wdata = scratch_reg[col_reg];
        end
    end

    assign opnd_we = accept && idx_ok &&
                     ((cmd.op == OP_MUL) || (cmd.op == OP_ADD) || (cmd.op == OP_CMP));

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rdata_reg <= acc_mem[acc_raddr];
        acc_rdiag_reg <= DIAG_MASK[acc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (opnd_we)
        begin
            opnd_mem[cmd_addr] <= cmd.elem_value;
        end
        opnd_rdata_reg <= opnd_mem[opnd_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg  <= '0;
            acc_rvld_reg <= 1'b0;
        end
        else
        begin
            acc_rvld_reg <= acc_vld_reg[acc_raddr];
            if (acc_we)
            begin
                acc_vld_reg[acc_waddr] <= 1'b1;
            end
        end
    end

    // Multiply pipeline: product, then floor shift, saturation and the row sum.
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign term       = sat_wide(prod_shift);
    assign sum_base   = p2_reg.first ? '0 : sum_reg;
    assign sum_next   = sum_base + {{(SUM_W-DATA_W){term[DATA_W-1]}}, term};

    // Only multiply tags move on to the accumulate stage.
    always_comb
    begin
        p2_next     = p1_reg;
        p2_next.vld = p1_reg.vld && (p1_reg.kind == T_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
        end
        else
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= (2*DATA_W)'(acc_val) * (2*DATA_W)'(opnd_rdata_reg);
        if (p2_reg.vld)
        begin
            sum_reg <= sum_next;
            if (p2_reg.last)
            begin
                scratch_reg[p2_reg.col] <= sat_sum(sum_next);
            end
        end
        if (p1_reg.vld && (p1_reg.kind == T_CMP))
        begin
            eq_reg <= (acc_val == opnd_rdata_reg) && (p1_reg.first || eq_reg);
        end
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            kk_reg        <= '0;
            seq_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (p1_reg.vld && (p1_reg.kind == T_RD))
            begin
                rsp_valid_reg     <= 1'b1;
                rsp_reg.kind      <= KIND_ELEM;
                rsp_reg.out_index <= 4'(p1_reg.idx);
                rsp_reg.out_value <= acc_val;
                rsp_reg.equal     <= 1'b0;
                rsp_reg.last      <= p1_reg.last;
            end
            else if ((state_reg == S_CMP_OUT) && slot_free)
            begin
                rsp_valid_reg     <= 1'b1;
                rsp_reg.kind      <= KIND_CMP;
                rsp_reg.out_index <= '0;
                rsp_reg.out_value <= '0;
                rsp_reg.equal     <= eq_reg;
                rsp_reg.last      <= 1'b0;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                    kk_reg  <= '0;
                    seq_reg <= '0;
                    if (accept)
                    begin
                        if (cmd.op == OP_READ)
                        begin
                            state_reg <= S_RD_RUN;
                        end
                        else if (idx_ok && idx_final)
                        begin
                            if (cmd.op == OP_MUL)
                                state_reg <= S_MUL_RUN;
                            else if (cmd.op == OP_ADD)
                                state_reg <= S_ADD_RUN;
                            else if (cmd.op == OP_CMP)
                                state_reg <= S_CMP_RUN;
                        end
                    end
                end
                S_MUL_RUN:
                begin
                    if (int'(kk_reg) == DIM - 1)
                    begin
                        kk_reg <= '0;
                        if (int'(col_reg) == DIM - 1)
                        begin
                            col_reg   <= '0;
                            state_reg <= S_MUL_DRAIN;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        kk_reg <= kk_reg + 1'b1;
                    end
                end
                S_MUL_DRAIN:
                begin
                    // The row is complete once its last column sum lands in scratch.
                    if (p2_reg.vld && p2_reg.last && (int'(p2_reg.col) == DIM - 1))
                    begin
                        state_reg <= S_MUL_WB;
                    end
                end
                S_MUL_WB:
                begin
                    if (int'(col_reg) == DIM - 1)
                    begin
                        col_reg <= '0;
                        if (int'(row_reg) == DIM - 1)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= S_MUL_RUN;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                S_ADD_RUN:
                begin
                    seq_reg <= seq_reg + 1'b1;
                    if (int'(seq_reg) == NELEM - 1)
                    begin
                        state_reg <= S_ADD_FIN;
                    end
                end
                S_ADD_FIN:
                begin
                    state_reg <= S_IDLE;
                end
                S_CMP_RUN:
                begin
                    seq_reg <= seq_reg + 1'b1;
                    if (int'(seq_reg) == NELEM - 1)
                    begin
                        state_reg <= S_CMP_FIN;
                    end
                end
                S_CMP_FIN:
                begin
                    state_reg <= S_CMP_OUT;
                end
                S_CMP_OUT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RD_RUN:
                begin
                    if (rd_issue)
                    begin
                        seq_reg <= seq_reg + 1'b1;
                        if (int'(seq_reg) == READ_COUNT - 1)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/m4acc_checker.sv
// Port-level checker of the matrix accumulate unit and its bind to the top level.
module m4acc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input m4acc_pkg::rsp_t rsp
);
    import m4acc_pkg::*;

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed or dropped while stalled");

    // A compare result carries only its outcome.
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == KIND_CMP) |->
            (rsp.out_index == '0) && (rsp.out_value == '0) && !rsp.last)
        else $error("compare result carries element fields");

    // The last flag marks exactly the final element of a read-out.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == KIND_ELEM) |->
            !rsp.equal && (rsp.last == (int'(rsp.out_index) == READ_COUNT - 1)))
        else $error("read-out last flag misplaced");

    // No new request is taken before a read-out has issued its final element.
    a_busy_rd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == KIND_ELEM) && !rsp.last |-> !cmd_ready)
        else $error("request accepted in the middle of a read-out");

endmodule

bind matrix4_accumulate_unit m4acc_checker u_m4acc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
